@@ src/free_list_page_allocator_core_assert.svh @@
`ifndef FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FLPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FLPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/flpa_pkg.sv @@
package flpa_pkg;

	localparam int PAGE_W  = 10;
	localparam int COUNT_W = 11;
	localparam int LINK_DEPTH = 1024;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [PAGE_W-1:0] page_number;
	} in_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number_res;
		logic [1:0]        status;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GROW,
		ST_SETTLE
	} state_t;

	typedef struct packed {
		logic load;
		logic push;
		logic pop;
		logic reject_free;
		logic reject_full;
		logic grow_start;
		logic grow_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op_free;
		logic head_zero;
		logic free_ok;
		logic grow_ok;
		logic grow_last;
	} ctrl_sts_t;

endpackage

@@ src/free_list_page_allocator_core.sv @@
// channel   signals                       transfer
// request   start, busy, item             start high and busy low at a rising edge
// result    done, result                  done high for one cycle, always taken
//
// Free and allocate from a non-empty list: the accept edge moves to EXEC, and the
// result is strobed in the cycle after EXEC.
// Empty-list allocate: EXEC, then GROW writes C links, C the page count before
// doubling, one a cycle on the link memory's single write port; then SETTLE, EXEC.
// arst_n clears head, done and state, sets count to 1; links need no clearing.
// The receiver cannot stall; a new start is accepted while done is high.
module free_list_page_allocator_core
	import flpa_pkg::*;
#(
	parameter int MAX_PAGES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	output logic      done,
	output out_item_t result
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	flpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	flpa_datapath #(
		.MAX_PAGES (MAX_PAGES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

@@ src/flpa_ctrl.sv @@
module flpa_ctrl
	import flpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd,
	output logic      busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!sts.op_free && sts.head_zero && sts.grow_ok) state_d = ST_GROW;
				else state_d = ST_IDLE;
			end
			ST_GROW: begin
				if (sts.grow_last) state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				state_d = ST_EXEC;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_EXEC: begin
				if (sts.op_free) begin
					cmd.push        = sts.free_ok;
					cmd.reject_free = !sts.free_ok;
				end else if (!sts.head_zero) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.grow_start  = sts.grow_ok;
					cmd.reject_full = !sts.grow_ok;
				end
			end
			ST_GROW: begin
				cmd.grow_step = 1'b1;
			end
			ST_SETTLE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/flpa_datapath.sv @@
module flpa_datapath
	import flpa_pkg::*;
#(
	parameter int MAX_PAGES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts,
	output logic      done,
	output out_item_t result
);

	localparam int CAP = (MAX_PAGES > LINK_DEPTH) ? LINK_DEPTH : MAX_PAGES;

	logic [PAGE_W-1:0] mem [LINK_DEPTH];

	in_item_t           op_q;
	logic [PAGE_W-1:0]  head_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [PAGE_W-1:0]  rdata_q;
	logic               done_q;
	out_item_t          res_q;

	logic [COUNT_W:0]   count_x2;
	logic               we;
	logic [PAGE_W-1:0]  waddr;
	logic [PAGE_W-1:0]  wdata;
	logic [PAGE_W-1:0]  grow_link;

	assign count_x2  = {count_q, 1'b0};
	assign grow_link = (cnt_q == count_q) ? '0 : PAGE_W'(cnt_q - COUNT_W'(1));

	assign sts.op_free   = (op_q.mode == MODE_FREE);
	assign sts.head_zero = (head_q == '0);
	assign sts.free_ok   = (op_q.page_number != '0)
		&& ({1'b0, op_q.page_number} < count_q);
	assign sts.grow_ok   = (count_x2 <= (COUNT_W+1)'(CAP));
	assign sts.grow_last = ({1'b0, cnt_q} == (count_x2 - (COUNT_W+1)'(1)));

	always_comb begin
		we    = cmd.push || cmd.grow_step;
		waddr = cmd.push ? op_q.page_number : cnt_q[PAGE_W-1:0];
		wdata = cmd.push ? head_q : grow_link;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= item;
		end
		if (cmd.grow_start) begin
			cnt_q <= count_q;
		end else if (cmd.grow_step) begin
			cnt_q <= cnt_q + COUNT_W'(1);
		end
		if (cmd.pop) begin
			res_q <= '{page_number_res: head_q, status: STATUS_OK};
		end else if (cmd.push) begin
			res_q <= '{page_number_res: '0, status: STATUS_OK};
		end else if (cmd.reject_free) begin
			res_q <= '{page_number_res: '0, status: STATUS_BAD_FREE};
		end else if (cmd.reject_full) begin
			res_q <= '{page_number_res: '0, status: STATUS_FULL};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= COUNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.pop || cmd.push || cmd.reject_free || cmd.reject_full;
			if (cmd.push) begin
				head_q <= op_q.page_number;
			end else if (cmd.pop) begin
				head_q <= rdata_q;
			end else if (cmd.grow_step && sts.grow_last) begin
				head_q  <= cnt_q[PAGE_W-1:0];
				count_q <= count_x2[COUNT_W-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ src/flpa_checker.sv @@
`include "free_list_page_allocator_core_assert.svh"

module flpa_checker
	import flpa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input in_item_t  item,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	logic err_res;

	assign err_res = done && (result.status != STATUS_OK);

	`FLPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept not followed by work")
	`FLPA_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without work in progress")
	`FLPA_ASSERT_NOW(a_status_code, done, result.status <= STATUS_BAD_FREE, "bad status code")
	`FLPA_ASSERT_NOW(a_error_page, err_res, result.page_number_res == '0, "error returned a page")

endmodule

bind free_list_page_allocator_core flpa_checker u_flpa_checker (.*);
